// File: design/owft_pkg.sv
// Package for the overwrite-oldest sample FIFO with latency trim.
// Holds the default sizes, the field widths and positions, and the transaction kind codes.
// Depends on nothing.
package owft_pkg;

  localparam int CAPACITY_DEFAULT = 4096;
  localparam int MAX_READ_DEFAULT = 64;

  localparam int KIND_W  = 2;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;
  localparam int KEEP_W  = 13;
  localparam int LEVEL_W = 13;

  localparam int COUNT_LSB = WORD_W;
  localparam int KEEP_LSB  = COUNT_LSB + COUNT_W;
  localparam int IN_DATA_W = ((KEEP_LSB + KEEP_W + 7) / 8) * 8;

  localparam int LEVEL_LSB  = WORD_W;
  localparam int OUT_DATA_W = ((LEVEL_LSB + LEVEL_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_READ   = 2'd1,
    KIND_LATEST = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

endpackage

// File: design/owft_ram.sv
// Single-port-write, single-port-read sample memory with registered read data.
// Used by the overwrite-oldest sample FIFO top level; depends on nothing else.
module owft_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/overwrite_fifo_with_latency_trim.sv
// Top level of the overwrite-oldest sample FIFO with latency trim.
// Depends on owft_pkg and owft_ram.
//
// A ring buffer of CAPACITY 32-bit sample words. A push transaction writes one word and, when
// the buffer is full, drops the oldest; a clear empties it. Both are handled in S_IDLE, and the
// block takes the next transaction in the following cycle. A read delivers up to max_count
// (saturated at MAX_READ) of the oldest words, one result per word with tlast on the final
// one, or a single result with tuser low and tlast high when nothing is available. A read
// latest with a nonzero max_count first drops the oldest words until at most max(keep_limit,
// max_count) remain. A read passes the setup states S_TRIM and S_START and then, per delivered
// word, S_FETCH to fetch the word from the registered read port of the sample memory and S_LOAD
// to load the output register; a read with nothing to deliver goes from setup to S_LOAD for its
// single result; a stalled output holds S_LOAD. The input side is not ready while a read is in
// progress, but becomes ready as soon as its final result is in the output register. Every
// result reports the fill level after it. The memory is not cleared after reset.
module overwrite_fifo_with_latency_trim #(
  parameter int CAPACITY = owft_pkg::CAPACITY_DEFAULT,
  parameter int MAX_READ = owft_pkg::MAX_READ_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0: sample_word, max_count, keep_limit, zero fill.
  input  logic [owft_pkg::IN_DATA_W-1:0]  s_tdata,
  // Fields from bit 0: kind.
  input  logic [owft_pkg::KIND_W-1:0]     s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0: sample_out, fill_level, zero fill.
  output logic [owft_pkg::OUT_DATA_W-1:0] m_tdata,
  // Fields from bit 0: sample_valid.
  output logic                            m_tuser,
  output logic                            m_tlast
);

  import owft_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > KEEP_W) ? CW : KEEP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIM,
    S_START,
    S_FETCH,
    S_LOAD
  } state_t;

  state_t              state;
  logic [AW-1:0]       rd_idx;
  logic [AW-1:0]       wr_idx;
  logic [CW-1:0]       fill;
  logic [COUNT_W-1:0]  req;
  logic [KEEP_W-1:0]   keep;
  logic                is_latest;
  logic [COUNT_W-1:0]  remaining;
  logic                empty;
  logic                out_valid;
  logic [WORD_W-1:0]   out_word;
  logic [LEVEL_W-1:0]  out_level;
  logic                out_sval;
  logic                out_last;

  logic                in_accept;
  kind_t               in_kind;
  logic [WORD_W-1:0]   in_word;
  logic [COUNT_W-1:0]  in_count;
  logic [COUNT_W-1:0]  in_count_sat;
  logic [KEEP_W-1:0]   in_keep;

  logic [WW-1:0]       fill_w;
  logic [WW-1:0]       req_w;
  logic [WW-1:0]       keep_w;
  logic [WW-1:0]       bound_w;
  logic                do_trim;
  logic [AW:0]         trim_sum;
  logic [AW-1:0]       trim_idx;
  logic [COUNT_W-1:0]  n_deliver;
  logic                out_free;
  logic                final_word;

  logic                ram_wr_en;
  logic                ram_rd_en;
  logic [WORD_W-1:0]   ram_rd_data;

  function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] idx);
    logic [AW-1:0] res;
    if (idx == AW'(CAPACITY - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_kind   = kind_t'(s_tuser);
  assign in_word   = s_tdata[WORD_W-1:0];
  assign in_count  = s_tdata[COUNT_LSB +: COUNT_W];
  assign in_keep   = s_tdata[KEEP_LSB +: KEEP_W];
  assign in_count_sat = (in_count > COUNT_W'(MAX_READ)) ? COUNT_W'(MAX_READ) : in_count;

  assign fill_w  = WW'(fill);
  assign req_w   = WW'(req);
  assign keep_w  = WW'(keep);
  assign bound_w = (keep_w > req_w) ? keep_w : req_w;
  assign do_trim = is_latest && (req != '0) && (fill_w > bound_w);
  assign trim_sum = {1'b0, rd_idx} + (AW + 1)'(fill_w - bound_w);
  assign trim_idx = (trim_sum >= (AW + 1)'(CAPACITY)) ?
                    AW'(trim_sum - (AW + 1)'(CAPACITY)) : AW'(trim_sum);
  assign n_deliver = (fill_w < req_w) ? COUNT_W'(fill) : req;

  assign out_free   = !out_valid || m_tready;
  assign final_word = empty || (remaining == '0);

  assign ram_wr_en = in_accept && (in_kind == KIND_PUSH);
  assign ram_rd_en = (state == S_FETCH);

  owft_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_idx),
    .wr_data (in_word),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_idx),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_idx    <= '0;
      wr_idx    <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_LOAD) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            case (in_kind)
              KIND_PUSH: begin
                if (fill == CW'(CAPACITY)) begin
                  rd_idx <= inc_idx(rd_idx);
                end else begin
                  fill <= fill + 1'b1;
                end
                wr_idx <= inc_idx(wr_idx);
              end
              KIND_CLEAR: begin
                rd_idx <= '0;
                wr_idx <= '0;
                fill   <= '0;
              end
              default: begin
                req       <= in_count_sat;
                keep      <= in_keep;
                is_latest <= (in_kind == KIND_LATEST);
                state     <= S_TRIM;
              end
            endcase
          end
        end
        S_TRIM: begin
          if (do_trim) begin
            rd_idx <= trim_idx;
            fill   <= CW'(bound_w);
          end
          state <= S_START;
        end
        S_START: begin
          remaining <= n_deliver;
          if (n_deliver == '0) begin
            empty <= 1'b1;
            state <= S_LOAD;
          end else begin
            empty <= 1'b0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          rd_idx    <= inc_idx(rd_idx);
          fill      <= fill - 1'b1;
          remaining <= remaining - 1'b1;
          state     <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            out_word  <= empty ? '0 : ram_rd_data;
            out_sval  <= !empty;
            out_last  <= final_word;
            out_level <= LEVEL_W'(fill);
            state     <= final_word ? S_IDLE : S_FETCH;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'({out_level, out_word});
  assign m_tuser  = out_sval;
  assign m_tlast  = out_last;

endmodule

// File: design/owft_checker.sv
// Port-level checker for the overwrite-oldest sample FIFO, bound to its top level.
// Depends on owft_pkg and on the ports of overwrite_fifo_with_latency_trim.
module owft_checker #(
  parameter int CAPACITY = owft_pkg::CAPACITY_DEFAULT
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [owft_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [owft_pkg::KIND_W-1:0]     s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [owft_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);

  import owft_pkg::*;

  logic                in_run;
  logic [LEVEL_W-1:0]  prev_level;
  logic [LEVEL_W-1:0]  level;
  logic                out_accept;

  assign level      = m_tdata[LEVEL_LSB +: LEVEL_W];
  assign out_accept = m_tvalid && m_tready;

  // Tracks whether a read is between its results, and the fill level of the last result.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
    end else if (out_accept) begin
      in_run     <= m_tuser && !m_tlast;
      prev_level <= level;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("Stalled output transaction changed.");

  a_invalid_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("Result without a sample is not the last of its read.");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (CAPACITY >= (1 << LEVEL_W)) || (int'(level) <= CAPACITY))
    else $error("Fill level exceeds the capacity.");

  a_level_step: assert property (@(posedge clk) disable iff (rst)
    in_run && m_tvalid |-> level == prev_level - 1'b1)
    else $error("Fill level did not drop by one within a read.");

  a_busy_in_run: assert property (@(posedge clk) disable iff (rst)
    in_run && !(m_tvalid && m_tlast) |-> !s_tready)
    else $error("Input ready while a read is still delivering.");

endmodule

bind overwrite_fifo_with_latency_trim owft_checker #(.CAPACITY(CAPACITY)) u_owft_checker (.*);

// File: tb/owft_result_monitor.sv
// Result monitor for the overwrite-oldest sample FIFO with latency trim.
// Watches both stream channels, predicts every result, and compares each delivered result.
// Depends on owft_pkg.
`timescale 1ns / 1ps

module owft_result_monitor
  import owft_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT,
  parameter int MAX_READ = MAX_READ_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]     s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tuser,
  input  logic                  m_tlast,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic               valid;
    logic               is_last;
    logic [LEVEL_W-1:0] level;
  } sample_result_t;

  sample_result_t    queued_samples[$];
  logic [WORD_W-1:0] ring [CAPACITY];
  int unsigned       head;
  int unsigned       tail;
  int unsigned       level;

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 100) begin
      $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  task automatic model_fifo_transaction(input kind_t kind, input logic [WORD_W-1:0] word,
                                        input logic [COUNT_W-1:0] count_in,
                                        input logic [KEEP_W-1:0] keep);
    int unsigned    want;
    int unsigned    bound;
    int unsigned    n;
    sample_result_t res;
    want = (count_in > MAX_READ) ? MAX_READ : count_in;
    case (kind)
      KIND_PUSH: begin
        if (level >= CAPACITY) begin
          head = (head + 1) % CAPACITY;
          level = CAPACITY - 1;
        end
        ring[tail] = word;
        tail = (tail + 1) % CAPACITY;
        level++;
      end
      KIND_CLEAR: begin
        head = 0;
        tail = 0;
        level = 0;
      end
      default: begin
        if (kind == KIND_LATEST && want != 0) begin
          bound = (keep > want) ? keep : want;
          if (level > bound) begin
            head = (head + level - bound) % CAPACITY;
            level = bound;
          end
        end
        n = (want < level) ? want : level;
        if (n == 0) begin
          res.word = '0;
          res.valid = 1'b0;
          res.is_last = 1'b1;
          res.level = LEVEL_W'(level);
          queued_samples.push_back(res);
        end else begin
          for (int i = 0; i < n; i++) begin
            res.word = ring[head];
            head = (head + 1) % CAPACITY;
            level--;
            res.valid = 1'b1;
            res.is_last = (i + 1 == n);
            res.level = LEVEL_W'(level);
            queued_samples.push_back(res);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    sample_result_t exp_res;
    if (rst) begin
      queued_samples.delete();
      head = 0;
      tail = 0;
      level = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (queued_samples.size() == 0) begin
          report_mismatch("result with nothing expected", m_tdata[WORD_W-1:0], 32'h0);
        end else begin
          exp_res = queued_samples.pop_front();
          if (m_tdata[WORD_W-1:0] !== exp_res.word) begin
            report_mismatch("sample_out", m_tdata[WORD_W-1:0], exp_res.word);
          end
          if (m_tuser !== exp_res.valid) begin
            report_mismatch("sample_valid", 32'(m_tuser), 32'(exp_res.valid));
          end
          if (m_tlast !== exp_res.is_last) begin
            report_mismatch("last", 32'(m_tlast), 32'(exp_res.is_last));
          end
          if (m_tdata[LEVEL_LSB +: LEVEL_W] !== exp_res.level) begin
            report_mismatch("fill_level", 32'(m_tdata[LEVEL_LSB +: LEVEL_W]),
                            32'(exp_res.level));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        model_fifo_transaction(kind_t'(s_tuser), s_tdata[WORD_W-1:0],
                               s_tdata[COUNT_LSB +: COUNT_W], s_tdata[KEEP_LSB +: KEEP_W]);
      end
    end
    pending_count = queued_samples.size();
  end

endmodule

// File: tb/tb_overwrite_fifo_with_latency_trim.sv
// Testbench top for the overwrite-oldest sample FIFO with latency trim.
// Drives directed and random transactions with random stalls and gives the verdict.
// Depends on owft_pkg, the block itself, and owft_result_monitor.
`timescale 1ns / 1ps

module tb_overwrite_fifo_with_latency_trim;
  import owft_pkg::*;

  localparam int RANDOM_ITEMS = 340;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [KIND_W-1:0]     s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  int fail_count;
  int pending_count;
  int sent_count;
  int stall_cycles;
  bit quiet;
  bit hold_request;

  overwrite_fifo_with_latency_trim uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  owft_result_monitor monitor (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [COUNT_W-1:0] rand_count();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return COUNT_W'($urandom_range(MAX_READ_DEFAULT + 1, 127));
    return COUNT_W'($urandom_range(1, MAX_READ_DEFAULT));
  endfunction

  function automatic logic [KEEP_W-1:0] rand_keep();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return KEEP_W'($urandom_range(0, 100));
    if (pick < 17) return KEEP_W'($urandom_range(0, CAPACITY_DEFAULT));
    return KEEP_W'($urandom_range(0, 8191));
  endfunction

  // Offers one transaction, after an optional idle burst, and returns once it is accepted.
  task automatic send_item(input kind_t kind, input logic [WORD_W-1:0] word,
                           input logic [COUNT_W-1:0] count, input logic [KEEP_W-1:0] keep);
    logic [IN_DATA_W-1:0] packed_in;
    int                   gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata <= IN_DATA_W'({$urandom, $urandom});
      s_tuser <= KIND_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    packed_in = '0;
    packed_in[WORD_W-1:0] = word;
    packed_in[COUNT_LSB +: COUNT_W] = count;
    packed_in[KEEP_LSB +: KEEP_W] = keep;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= packed_in;
    s_tuser <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  initial begin
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int pick;
    int burst;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = KIND_PUSH;
    quiet = 1'b0;
    hold_request = 1'b0;
    sent_count = 0;
    stall_cycles = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reads on an empty buffer, then the extremes of the sample word.
    send_item(KIND_READ, 32'h1234_5678, 7'd5, 13'd0);
    send_item(KIND_LATEST, 32'h0, 7'd5, 13'd0);
    send_item(KIND_PUSH, 32'h0000_0000, 7'd0, 13'd0);
    send_item(KIND_PUSH, 32'hFFFF_FFFF, 7'd127, 13'd8191);
    send_item(KIND_PUSH, 32'hA5A5_A5A5, 7'd0, 13'd0);
    send_item(KIND_PUSH, 32'h5A5A_5A5A, 7'd0, 13'd0);
    send_item(KIND_READ, 32'hFFFF_FFFF, 7'd0, 13'd8191);
    send_item(KIND_LATEST, 32'h0, 7'd0, 13'd0);
    send_item(KIND_READ, 32'h0, 7'd2, 13'd0);
    send_item(KIND_READ, 32'h0, 7'd127, 13'd0);

    // Trim down to the keep limit, then read latest with a saturated max_count.
    repeat (10) send_item(KIND_PUSH, $urandom, rand_count(), rand_keep());
    send_item(KIND_LATEST, 32'h0, 7'd3, 13'd5);
    send_item(KIND_LATEST, 32'h0, 7'd100, 13'd0);

    send_item(KIND_PUSH, $urandom, 7'd0, 13'd0);
    send_item(KIND_PUSH, $urandom, 7'd0, 13'd0);
    send_item(KIND_CLEAR, $urandom, 7'd127, 13'd8191);
    send_item(KIND_READ, 32'h0, 7'd4, 13'd0);

    // Build a backlog of a hundred words, then read it out in several ways.
    repeat (100) send_item(KIND_PUSH, $urandom, rand_count(), rand_keep());
    send_item(KIND_READ, 32'h0, 7'd0, 13'd0);
    send_item(KIND_LATEST, 32'h0, 7'd64, 13'd8191);
    send_item(KIND_LATEST, 32'h0, 7'd1, 13'd1000);
    send_item(KIND_LATEST, 32'h0, 7'd64, 13'd4096);
    send_item(KIND_CLEAR, 32'h0, 7'd0, 13'd0);

    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      if (sent_count >= HOLD_AT && sent_count < HOLD_AT + 100 && !quiet) begin
        hold_request = 1'b1;
        quiet = 1'b0;
      end
      if (sent_count >= RANDOM_ITEMS - 60) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        burst = $urandom_range(1, 40);
        repeat (burst) send_item(KIND_PUSH, $urandom, rand_count(), rand_keep());
        send_item($urandom_range(0, 1) ? KIND_LATEST : KIND_READ, $urandom, rand_count(),
                  rand_keep());
      end else if (pick < 97) begin
        send_item(kind_t'($urandom_range(0, 2)), $urandom, rand_count(), rand_keep());
      end else begin
        send_item(KIND_CLEAR, $urandom, rand_count(), rand_keep());
      end
      if (sent_count >= HOLD_AT) hold_request = hold_request && (sent_count < HOLD_AT + 1);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
